>>> rtl/cfa_pkg.sv
// Shared types and constants of the Coulomb field accumulator.
package cfa_pkg;

  localparam int COORD_W  = 32;
  localparam int FIELD_W  = 48;
  localparam int CHARGE_W = 32;
  localparam int K_W      = 32;
  localparam int MIND_W   = 31;
  localparam int DIR_W    = 32;
  localparam int FRAC_DIR = 30;
  localparam int CNT_W    = 8;
  localparam int CFG_IDX_W = 3;

  localparam logic [K_W-1:0]    K_RESET    = 32'd16777216;
  localparam logic [MIND_W-1:0] MIND_RESET = 31'd66;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_EVAL_X = 3'd0,
    CFG_EVAL_Y = 3'd1,
    CFG_EVAL_Z = 3'd2,
    CFG_K      = 3'd3,
    CFG_MIND   = 3'd4
  } cfg_e;

  typedef enum logic [1:0] {
    OP_MUL  = 2'd0,
    OP_DIV  = 2'd1,
    OP_SQRT = 2'd2
  } op_e;

  typedef struct packed {
    logic             start;
    op_e              op;
    logic [CNT_W-1:0] n;
  } cmd_t;

endpackage

>>> rtl/cfa_if.sv
// Item channels of the Coulomb field accumulator.
interface cfa_in_if #(parameter int CW = 32);
  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] pos_x;
  logic signed [CW-1:0] pos_y;
  logic signed [CW-1:0] pos_z;
  logic signed [31:0]   charge;
  logic                 last;
  modport source (output valid, pos_x, pos_y, pos_z, charge, last, input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, charge, last, output ready);
endinterface

interface cfa_out_if #(parameter int FW = 48);
  logic                 valid;
  logic                 ready;
  logic signed [FW-1:0] field_x;
  logic signed [FW-1:0] field_y;
  logic signed [FW-1:0] field_z;
  logic        [FW-1:0] field_mag;
  logic signed [31:0]   dir_x;
  logic signed [31:0]   dir_y;
  logic signed [31:0]   dir_z;
  modport source (output valid, field_x, field_y, field_z, field_mag, dir_x, dir_y, dir_z,
                  input ready);
  modport sink   (input valid, field_x, field_y, field_z, field_mag, dir_x, dir_y, dir_z,
                  output ready);
endinterface

>>> rtl/coulomb_field_accumulator.sv
// Top level of the Coulomb field accumulator: registers, sequencer and accumulators.
//
//  channel | dir | handshake          | payload
//  cfg     | in  | cfg_we_i           | cfg_idx_i, cfg_data_i
//  in_i    | in  | valid/ready        | pos_x, pos_y, pos_z, charge, last
//  out_o   | out | valid/ready        | field_x/y/z, field_mag, dir_x/y/z
//
// Every step runs on one shared bit-serial unit.
// Reset clears control, accumulators and configuration registers to their defaults; no clearing pass.
// in_i is ready only when idle; a pending result waits in the output register while the
// next item is taken, and a new result waits for it to drain.
module coulomb_field_accumulator #(
  parameter int COORD_WIDTH = cfa_pkg::COORD_W,
  parameter int FIELD_WIDTH = cfa_pkg::FIELD_W
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        cfg_we_i,
  input  logic [cfa_pkg::CFG_IDX_W-1:0]               cfg_idx_i,
  input  logic [((COORD_WIDTH > 32) ? COORD_WIDTH : 32)-1:0] cfg_data_i,
  cfa_in_if.sink                                      in_i,
  cfa_out_if.source                                   out_o
);
  import cfa_pkg::*;

  localparam int CW  = COORD_WIDTH;
  localparam int FW  = FIELD_WIDTH;
  localparam int AW  = CW + 1;
  localparam int D2W = 2 * AW;
  localparam int UW0 = (2 * FW > D2W) ? 2 * FW : D2W;
  localparam int UW  = (UW0 > 96) ? UW0 : 96;
  localparam int KQW = K_W + CHARGE_W;
  localparam int MNW = KQW + 16;
  localparam int LIMW = 2 * MIND_W;

  localparam logic signed [FW-1:0] FMAX = {1'b0, {(FW-1){1'b1}}};
  localparam logic signed [FW-1:0] FMIN = {1'b1, {(FW-1){1'b0}}};

  typedef enum logic [12:0] {
    S_IDLE  = 13'b0000000000001,
    S_SQ    = 13'b0000000000010,
    S_LIM   = 13'b0000000000100,
    S_ROOT  = 13'b0000000001000,
    S_KQ    = 13'b0000000010000,
    S_M     = 13'b0000000100000,
    S_U     = 13'b0000001000000,
    S_P     = 13'b0000010000000,
    S_FIN   = 13'b0000100000000,
    S_LSQ   = 13'b0001000000000,
    S_LROOT = 13'b0010000000000,
    S_DIR   = 13'b0100000000000,
    S_OUT   = 13'b1000000000000
  } state_e;

  state_e state_q;
  logic   go_q;
  logic [1:0] idx_q;

  logic signed [CW-1:0] eval_x_q, eval_y_q, eval_z_q;
  logic [K_W-1:0]       k_q;
  logic [MIND_W-1:0]    mind_q;

  logic [AW-1:0]        ar_q [3];
  logic                 sgn_q [3];
  logic [CHARGE_W-1:0]  aq_q;
  logic                 qneg_q, last_q;
  logic [D2W-1:0]       d2_q;
  logic [AW-1:0]        d_q;
  logic [63:0]          m_q;
  logic [30:0]          u_q;
  logic [2*FW-1:0]      sq_q;
  logic [FW-1:0]        mag_q;
  logic signed [FW-1:0] sum_q [3];
  logic signed [DIR_W-1:0] dir_q [3];

  logic                 out_valid_q;
  logic signed [FW-1:0] ofx_q, ofy_q, ofz_q;
  logic [FW-1:0]        omag_q;
  logic signed [DIR_W-1:0] odx_q, ody_q, odz_q;

  cmd_t          cmd;
  logic [UW-1:0] ua, ub, ures;
  logic          udone;

  logic signed [AW-1:0] dx, dy, dz;
  logic signed [FW-1:0] cur_sum;
  logic [FW-1:0]        abs_sum;
  logic [64:0]          pm;
  logic                 cneg, cbig;
  logic signed [FW-1:0] contrib;
  logic signed [FW:0]   sadd;
  logic signed [FW-1:0] sat_sum;
  logic [MNW-1:0]       mquot;
  logic [DIR_W-1:0]     dquot;
  logic                 in_acc;
  logic                 drop;
  logic                 zero_mag;
  logic                 go_d;
  logic                 out_load;

  cfa_iter_unit #(.UW(UW)) u_iter (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .a_i    (ua),
    .b_i    (ub),
    .done_o (udone),
    .res_o  (ures)
  );

  always_comb begin
    dx = {eval_x_q[CW-1], eval_x_q} - {in_i.pos_x[CW-1], in_i.pos_x};
    dy = {eval_y_q[CW-1], eval_y_q} - {in_i.pos_y[CW-1], in_i.pos_y};
    dz = {eval_z_q[CW-1], eval_z_q} - {in_i.pos_z[CW-1], in_i.pos_z};

    cur_sum = sum_q[idx_q];
    abs_sum = cur_sum[FW-1] ? FW'(-cur_sum) : FW'(cur_sum);

    // contribution of one component, saturated, then added with saturation
    pm      = ures[94:30];
    cneg    = qneg_q ^ sgn_q[idx_q];
    cbig    = pm > 65'(FMAX);
    if (cbig) contrib = cneg ? FMIN : FMAX;
    else      contrib = cneg ? -$signed(pm[FW-1:0]) : $signed(pm[FW-1:0]);
    sadd = {cur_sum[FW-1], cur_sum} + {contrib[FW-1], contrib};
    if (sadd[FW] != sadd[FW-1]) sat_sum = sadd[FW] ? FMIN : FMAX;
    else                        sat_sum = sadd[FW-1:0];

    mquot = ures[MNW-1:0];
    dquot = ures[DIR_W-1:0];

    cmd.start = go_q;
    cmd.op    = OP_MUL;
    cmd.n     = CNT_W'(AW);
    ua        = UW'(ar_q[idx_q]);
    ub        = UW'(ar_q[idx_q]);
    case (state_q)
      S_LIM: begin
        cmd.n = CNT_W'(MIND_W);
        ua    = UW'(mind_q);
        ub    = UW'(mind_q);
      end
      S_ROOT: begin
        cmd.op = OP_SQRT;
        ua     = UW'(d2_q);
      end
      S_KQ: begin
        cmd.n = CNT_W'(CHARGE_W);
        ua    = UW'(k_q);
        ub    = UW'(aq_q);
      end
      S_M: begin
        cmd.op = OP_DIV;
        cmd.n  = CNT_W'(MNW);
        ua     = UW'({m_q, 16'h0000});
        ub     = UW'(d2_q);
      end
      S_U: begin
        cmd.op = OP_DIV;
        cmd.n  = CNT_W'(AW + FRAC_DIR);
        ua     = UW'(ar_q[idx_q]) << FRAC_DIR;
        ub     = UW'(d_q);
      end
      S_P: begin
        cmd.n = CNT_W'(31);
        ua    = UW'(m_q);
        ub    = UW'(u_q);
      end
      S_LSQ: begin
        cmd.n = CNT_W'(FW);
        ua    = UW'(abs_sum);
        ub    = UW'(abs_sum);
      end
      S_LROOT: begin
        cmd.op = OP_SQRT;
        cmd.n  = CNT_W'(FW);
        ua     = UW'(sq_q);
      end
      S_DIR: begin
        cmd.op = OP_DIV;
        cmd.n  = CNT_W'(FW + FRAC_DIR);
        ua     = UW'(abs_sum) << FRAC_DIR;
        ub     = UW'(mag_q);
      end
      default: ;
    endcase
  end

  assign in_i.ready = (state_q == S_IDLE);
  assign in_acc     = in_i.valid && (state_q == S_IDLE);
  assign out_load   = (state_q == S_OUT) && (!out_valid_q || out_o.ready);

  // drop a charge at the evaluation point or inside the minimum distance
  assign drop     = (d2_q == '0) || (UW'(d2_q) < UW'(ures[LIMW-1:0]));
  assign zero_mag = (ures[FW-1:0] == '0);

  // start the next operation of the shared unit
  always_comb begin
    go_d = 1'b0;
    case (state_q)
      S_IDLE:                               go_d = in_acc;
      S_SQ, S_ROOT, S_KQ, S_M, S_U, S_LSQ:  go_d = udone;
      S_LIM:                                go_d = udone && !drop;
      S_P, S_DIR:                           go_d = udone && (idx_q != 2'd2);
      S_FIN:                                go_d = last_q;
      S_LROOT:                              go_d = udone && !zero_mag;
      default:                              go_d = 1'b0;
    endcase
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eval_x_q <= '0;
      eval_y_q <= '0;
      eval_z_q <= '0;
      k_q      <= K_RESET;
      mind_q   <= MIND_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_EVAL_X: eval_x_q <= cfg_data_i[CW-1:0];
        CFG_EVAL_Y: eval_y_q <= cfg_data_i[CW-1:0];
        CFG_EVAL_Z: eval_z_q <= cfg_data_i[CW-1:0];
        CFG_K:      k_q      <= cfg_data_i[K_W-1:0];
        CFG_MIND:   mind_q   <= cfg_data_i[MIND_W-1:0];
        default: ;
      endcase
    end
  end

  // output valid: load a new result, drop it once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // sequencer and accumulators
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      go_q        <= 1'b0;
      idx_q       <= '0;
      sum_q[0]    <= '0;
      sum_q[1]    <= '0;
      sum_q[2]    <= '0;
    end else begin
      go_q <= go_d;
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            idx_q   <= '0;
            state_q <= S_SQ;
          end
        end
        S_SQ: begin
          if (udone) begin
            if (idx_q == 2'd2) begin
              idx_q   <= '0;
              state_q <= S_LIM;
            end else begin
              idx_q <= idx_q + 2'd1;
            end
          end
        end
        S_LIM: begin
          if (udone) begin
            if (drop) begin
              state_q <= S_FIN;
            end else begin
              state_q <= S_ROOT;
            end
          end
        end
        S_ROOT: begin
          if (udone) begin
            state_q <= S_KQ;
          end
        end
        S_KQ: begin
          if (udone) begin
            state_q <= S_M;
          end
        end
        S_M: begin
          if (udone) begin
            idx_q   <= '0;
            state_q <= S_U;
          end
        end
        S_U: begin
          if (udone) begin
            state_q <= S_P;
          end
        end
        S_P: begin
          if (udone) begin
            sum_q[idx_q] <= sat_sum;
            if (idx_q == 2'd2) begin
              state_q <= S_FIN;
            end else begin
              idx_q   <= idx_q + 2'd1;
              state_q <= S_U;
            end
          end
        end
        S_FIN: begin
          if (last_q) begin
            idx_q   <= '0;
            state_q <= S_LSQ;
          end else begin
            state_q <= S_IDLE;
          end
        end
        S_LSQ: begin
          if (udone) begin
            if (idx_q == 2'd2) begin
              idx_q   <= '0;
              state_q <= S_LROOT;
            end else begin
              idx_q <= idx_q + 2'd1;
            end
          end
        end
        S_LROOT: begin
          if (udone) begin
            // zero field: skip the divides, directions stay zero
            if (zero_mag) begin
              state_q <= S_OUT;
            end else begin
              state_q <= S_DIR;
            end
          end
        end
        S_DIR: begin
          if (udone) begin
            if (idx_q == 2'd2) begin
              state_q <= S_OUT;
            end else begin
              idx_q   <= idx_q + 2'd1;
            end
          end
        end
        S_OUT: begin
          if (out_load) begin
            sum_q[0]    <= '0;
            sum_q[1]    <= '0;
            sum_q[2]    <= '0;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      ar_q[0]  <= dx[AW-1] ? AW'(-dx) : AW'(dx);
      ar_q[1]  <= dy[AW-1] ? AW'(-dy) : AW'(dy);
      ar_q[2]  <= dz[AW-1] ? AW'(-dz) : AW'(dz);
      sgn_q[0] <= dx[AW-1];
      sgn_q[1] <= dy[AW-1];
      sgn_q[2] <= dz[AW-1];
      aq_q     <= in_i.charge[CHARGE_W-1] ? CHARGE_W'(-in_i.charge) : CHARGE_W'(in_i.charge);
      qneg_q   <= in_i.charge[CHARGE_W-1];
      last_q   <= in_i.last;
      d2_q     <= '0;
    end
    if (udone) begin
      case (state_q)
        S_SQ:    d2_q <= d2_q + ures[D2W-1:0];
        S_ROOT:  d_q  <= ures[AW-1:0];
        S_KQ:    m_q  <= ures[63:0];
        S_M:     m_q  <= (mquot[MNW-1:64] != '0) ? '1 : mquot[63:0];
        S_U:     u_q  <= ures[30:0];
        S_LSQ:   sq_q <= sq_q + ures[2*FW-1:0];
        S_LROOT: mag_q <= ures[FW-1:0];
        S_DIR:   dir_q[idx_q] <= cur_sum[FW-1] ? -$signed(dquot) : $signed(dquot);
        default: ;
      endcase
    end
    if (state_q == S_FIN) begin
      sq_q     <= '0;
      dir_q[0] <= '0;
      dir_q[1] <= '0;
      dir_q[2] <= '0;
    end
    if (out_load) begin
      ofx_q  <= sum_q[0];
      ofy_q  <= sum_q[1];
      ofz_q  <= sum_q[2];
      omag_q <= mag_q;
      odx_q  <= dir_q[0];
      ody_q  <= dir_q[1];
      odz_q  <= dir_q[2];
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.field_x   = ofx_q;
  assign out_o.field_y   = ofy_q;
  assign out_o.field_z   = ofz_q;
  assign out_o.field_mag = omag_q;
  assign out_o.dir_x     = odx_q;
  assign out_o.dir_y     = ody_q;
  assign out_o.dir_z     = odz_q;

endmodule

>>> rtl/cfa_iter_unit.sv
// Shared bit-serial unit: shift-add multiply, restoring divide, integer square root.
module cfa_iter_unit #(
  parameter int UW = 98
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cfa_pkg::cmd_t     cmd_i,
  input  logic [UW-1:0]     a_i,
  input  logic [UW-1:0]     b_i,
  output logic              done_o,
  output logic [UW-1:0]     res_o
);
  import cfa_pkg::*;

  localparam int RW = UW + 2;

  op_e              op_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q, done_q;
  logic [RW-1:0]    r_q;
  logic [UW-1:0]    q_q, x_q, y_q;

  logic [RW-1:0] rr_div, rr_sq, trial, sum_mul, y_ext;

  always_comb begin
    y_ext   = {2'b00, y_q};
    rr_div  = {r_q[RW-2:0], x_q[UW-1]};
    rr_sq   = {r_q[RW-3:0], x_q[UW-1:UW-2]};
    trial   = {q_q, 2'b01};
    sum_mul = r_q + y_ext;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q   <= OP_MUL;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= !cmd_i.start && busy_q && (cnt_q == CNT_W'(1));
      if (cmd_i.start) begin
        op_q   <= cmd_i.op;
        cnt_q  <= cmd_i.n;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      r_q <= '0;
      q_q <= '0;
      case (cmd_i.op)
        OP_MUL: begin
          x_q <= b_i;
          y_q <= a_i;
        end
        OP_DIV: begin
          // align the numerator's top bit to the MSB
          x_q <= a_i << (UW - int'(cmd_i.n));
          y_q <= b_i;
        end
        default: begin
          x_q <= a_i << (UW - 2 * int'(cmd_i.n));
          y_q <= b_i;
        end
      endcase
    end else if (busy_q) begin
      case (op_q)
        OP_MUL: begin
          if (x_q[0]) r_q <= sum_mul;
          x_q <= x_q >> 1;
          y_q <= y_q << 1;
        end
        OP_DIV: begin
          if (rr_div >= y_ext) begin
            r_q <= rr_div - y_ext;
            q_q <= {q_q[UW-2:0], 1'b1};
          end else begin
            r_q <= rr_div;
            q_q <= {q_q[UW-2:0], 1'b0};
          end
          x_q <= x_q << 1;
        end
        default: begin
          if (rr_sq >= trial) begin
            r_q <= rr_sq - trial;
            q_q <= {q_q[UW-2:0], 1'b1};
          end else begin
            r_q <= rr_sq;
            q_q <= {q_q[UW-2:0], 1'b0};
          end
          x_q <= x_q << 2;
        end
      endcase
    end
  end

  assign done_o = done_q;
  assign res_o  = (op_q == OP_MUL) ? r_q[UW-1:0] : q_q;

endmodule
